// ===== rtl/ftcb_pkg.sv =====
// Package with shared constants, codes and types for the fractional tick countdown bank.
package ftcb_pkg;

    localparam int NUM_TIMERS  = 4;
    localparam int TIMER_IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    localparam logic [6:0] RESET_INCREMENT = 7'd16;
    localparam logic [7:0] RESET_MODULUS   = 8'd125;
    localparam logic [5:0] LAST_SECOND     = 6'd59;

    localparam logic [1:0] CFG_INCREMENT = 2'd0;
    localparam logic [1:0] CFG_MODULUS   = 2'd1;
    localparam logic [1:0] CFG_ENABLE    = 2'd2;

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_LOAD = 1'b1;

    typedef struct packed {
        logic [7:0] minutes;
        logic [5:0] seconds;
        logic [7:0] subseconds;
        logic       running;
        logic       expired;
    } timer_entry_t;

    localparam int ENTRY_W = $bits(timer_entry_t);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_WRITE
    } state_t;

endpackage

// ===== rtl/ftcb_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module ftcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/fractional_tick_countdown_bank_unit.sv =====
// Top level of the fractional tick countdown bank: tick accumulator and timer sequencer.
//
//  Channel  | Direction | Contents
//  ---------+-----------+-------------------------------------------------------
//  s_*      | in        | tick or load word (tuser selects), one timer load
//  m_*      | out       | one status word per timer on each tick, tlast on final
//  cfg_*    | in        | increment, modulus and countdown enable registers
//
// A load word is accepted in the idle state and written straight to the timer memory.
// A tick is accepted in the idle state, then each timer is visited in turn (read the
// timer memory, then step and write back) before the sequencer returns to idle.
// Reset sets the registers, status data apart, to their defaults and clears the
// per-entry valid bits; an entry that was never written reads as zero. A stalled output
// holds the sequencer in the write-back state until the status word register frees up.
module fractional_tick_countdown_bank_unit
    import ftcb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // timer_index, load_minutes, load_seconds, load_subseconds, load_running
    input  logic [23:0] s_tdata,
    // action
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // result_index, minutes_left, seconds_left, is_running, has_expired,
    // timestamp, zero fill
    output logic [31:0] m_tdata,
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    state_t state_reg, state_next;

    logic [6:0] increment_reg;
    logic [7:0] modulus_reg;
    logic       enable_reg;

    logic [7:0] accum_reg, accum_next;
    logic [7:0] stamp_reg, stamp_next;

    logic [TIMER_IDX_W-1:0] idx_reg, idx_next;
    logic [NUM_TIMERS-1:0]  valid_reg, valid_next;

    logic        out_valid_reg, out_valid_next;
    logic [25:0] out_data_reg, out_data_next;
    logic        out_last_reg, out_last_next;

    logic [1:0]  in_index;
    logic [7:0]  in_minutes;
    logic [5:0]  in_seconds;
    logic [6:0]  in_subseconds;
    logic        in_running;

    logic                   accept;
    logic                   load_ok;
    logic                   out_free;
    logic                   step_write;
    logic                   ram_we;
    logic [TIMER_IDX_W-1:0] ram_wr_addr;
    timer_entry_t           ram_wr_data;
    logic [ENTRY_W-1:0]     ram_rd_data;
    timer_entry_t           cur_entry;
    timer_entry_t           step_entry;
    timer_entry_t           load_entry;
    logic [8:0]             accum_sum;
    logic                   idx_last;

    assign in_index      = s_tdata[1:0];
    assign in_minutes    = s_tdata[9:2];
    assign in_seconds    = s_tdata[15:10];
    assign in_subseconds = s_tdata[22:16];
    assign in_running    = s_tdata[23];

    assign accept   = s_tvalid && s_tready;
    assign load_ok  = (int'(in_index) < NUM_TIMERS);
    assign out_free = !out_valid_reg || m_tready;
    assign idx_last = (idx_reg == TIMER_IDX_W'(NUM_TIMERS - 1));

    ftcb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_TIMERS)
    ) u_timer_ram (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (idx_reg),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        if (valid_reg[idx_reg])
        begin
            cur_entry = timer_entry_t'(ram_rd_data);
        end
        else
        begin
            cur_entry = '0;
        end
    end

    // One countdown step of the timer that was just read.
    always_comb
    begin
        step_entry = cur_entry;
        if (enable_reg && cur_entry.running)
        begin
            if (cur_entry.subseconds >= {1'b0, increment_reg})
            begin
                step_entry.subseconds = cur_entry.subseconds - {1'b0, increment_reg};
            end
            else
            begin
                step_entry.subseconds = cur_entry.subseconds + modulus_reg
                                        - {1'b0, increment_reg};
                if (cur_entry.seconds != '0)
                begin
                    step_entry.seconds = cur_entry.seconds - 6'd1;
                end
                else if (cur_entry.minutes != '0)
                begin
                    step_entry.minutes = cur_entry.minutes - 8'd1;
                    step_entry.seconds = LAST_SECOND;
                end
                else
                begin
                    step_entry.running = 1'b0;
                    step_entry.expired = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        load_entry.minutes = in_minutes;
        load_entry.seconds = in_seconds;
        if ({1'b0, in_subseconds} >= modulus_reg)
        begin
            load_entry.subseconds = (modulus_reg == '0) ? 8'd0 : modulus_reg - 8'd1;
        end
        else
        begin
            load_entry.subseconds = {1'b0, in_subseconds};
        end
        load_entry.running = in_running;
        load_entry.expired = 1'b0;
    end

    assign accum_sum = {1'b0, accum_reg} + {2'b00, increment_reg};

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (s_tuser == ACT_TICK))
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    state_next = idx_last ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        s_tready   = 1'b0;
        step_write = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_READ:
            begin
                step_write = 1'b0;
            end
            ST_WRITE:
            begin
                step_write = out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        ram_we      = 1'b0;
        ram_wr_addr = idx_reg;
        ram_wr_data = step_entry;
        valid_next  = valid_reg;
        if (step_write)
        begin
            ram_we              = 1'b1;
            valid_next[idx_reg] = 1'b1;
        end
        else if (accept && (s_tuser == ACT_LOAD) && load_ok)
        begin
            ram_we                  = 1'b1;
            ram_wr_addr             = TIMER_IDX_W'(in_index);
            ram_wr_data             = load_entry;
            valid_next[ram_wr_addr] = 1'b1;
        end
    end

    always_comb
    begin
        accum_next = accum_reg;
        stamp_next = stamp_reg;
        idx_next   = idx_reg;
        if (accept && (s_tuser == ACT_TICK))
        begin
            idx_next = '0;
            if (accum_sum >= {1'b0, modulus_reg})
            begin
                accum_next = 8'(accum_sum - {1'b0, modulus_reg});
                stamp_next = stamp_reg + 8'd1;
            end
            else
            begin
                accum_next = accum_sum[7:0];
            end
        end
        else if (step_write && !idx_last)
        begin
            idx_next = idx_reg + TIMER_IDX_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (step_write)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {stamp_reg, step_entry.expired, step_entry.running,
                              step_entry.seconds, step_entry.minutes, 2'(idx_reg)};
            out_last_next  = idx_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            increment_reg <= RESET_INCREMENT;
            modulus_reg   <= RESET_MODULUS;
            enable_reg    <= 1'b0;
            accum_reg     <= '0;
            stamp_reg     <= '0;
            idx_reg       <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            accum_reg     <= accum_next;
            stamp_reg     <= stamp_next;
            idx_reg       <= idx_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_INCREMENT: increment_reg <= cfg_data[6:0];
                    CFG_MODULUS:   modulus_reg   <= cfg_data;
                    CFG_ENABLE:    enable_reg    <= cfg_data[0];
                    default:       enable_reg    <= enable_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b000000, out_data_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ===== test/timer_status_checker.sv =====
// Checker for the countdown bank: predicts status words from accepted words and compares them.
module timer_status_checker
    import ftcb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // timer_index, load_minutes, load_seconds, load_subseconds, load_running
    input  logic [23:0] s_tdata,
    // action
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // result_index, minutes_left, seconds_left, is_running, has_expired,
    // timestamp, zero fill
    input  logic [31:0] m_tdata,
    input  logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    output int          mismatches,
    output int          outstanding
);

    typedef struct {
        logic [1:0] index;
        logic [7:0] minutes;
        logic [5:0] seconds;
        logic       running;
        logic       expired;
        logic [7:0] stamp;
        logic       last;
    } timer_status_t;

    logic [6:0]    tick_step;
    logic [7:0]    tick_period;
    logic          countdown_on;
    logic [7:0]    frac_acc;
    logic [7:0]    second_count;
    timer_entry_t  timers [NUM_TIMERS];
    timer_status_t status_queue [$];
    timer_status_t want;

    initial
    begin
        mismatches = 0;
        outstanding = 0;
    end

    task report_mismatch(input string msg);
        mismatches++;
        $display("%0t: %s", $time, msg);
    endtask

    task check_field(input string name, input int got, input int want_v);
        if (got != want_v)
            report_mismatch($sformatf("timer %0d %s: got %0d, expected %0d",
                                      want.index, name, got, want_v));
    endtask

    function void load_timer(input logic [23:0] word);
        logic [1:0] idx;
        logic [7:0] sub;
        idx = word[1:0];
        sub = {1'b0, word[22:16]};
        if (idx < NUM_TIMERS)
        begin
            if (sub >= tick_period)
                sub = (tick_period == 8'd0) ? 8'd0 : tick_period - 8'd1;
            timers[idx].minutes    = word[9:2];
            timers[idx].seconds    = word[15:10];
            timers[idx].subseconds = sub;
            timers[idx].running    = word[23];
            timers[idx].expired    = 1'b0;
        end
    endfunction

    function void count_down(input int t);
        if (timers[t].running)
        begin
            if (timers[t].subseconds >= {1'b0, tick_step})
                timers[t].subseconds = timers[t].subseconds - {1'b0, tick_step};
            else
            begin
                timers[t].subseconds = timers[t].subseconds + tick_period - {1'b0, tick_step};
                if (timers[t].seconds != 6'd0)
                    timers[t].seconds = timers[t].seconds - 6'd1;
                else if (timers[t].minutes != 8'd0)
                begin
                    timers[t].minutes = timers[t].minutes - 8'd1;
                    timers[t].seconds = LAST_SECOND;
                end
                else
                begin
                    timers[t].running = 1'b0;
                    timers[t].expired = 1'b1;
                end
            end
        end
    endfunction

    function void advance_tick();
        logic [8:0]    sum;
        timer_status_t st;
        sum = {1'b0, frac_acc} + {2'b0, tick_step};
        if (sum >= {1'b0, tick_period})
        begin
            sum = sum - {1'b0, tick_period};
            second_count = second_count + 8'd1;
        end
        frac_acc = sum[7:0];
        if (countdown_on)
            for (int t = 0; t < NUM_TIMERS; t++)
                count_down(t);
        for (int t = 0; t < NUM_TIMERS; t++)
        begin
            st.index   = t[1:0];
            st.minutes = timers[t].minutes;
            st.seconds = timers[t].seconds;
            st.running = timers[t].running;
            st.expired = timers[t].expired;
            st.stamp   = second_count;
            st.last    = (t == NUM_TIMERS - 1);
            status_queue.push_back(st);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_step    = RESET_INCREMENT;
            tick_period  = RESET_MODULUS;
            countdown_on = 1'b0;
            frac_acc     = 8'd0;
            second_count = 8'd0;
            for (int t = 0; t < NUM_TIMERS; t++)
                timers[t] = '0;
            status_queue.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_INCREMENT: tick_step = cfg_data[6:0];
                    CFG_MODULUS:   tick_period = cfg_data;
                    CFG_ENABLE:    countdown_on = cfg_data[0];
                    default:       ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == ACT_LOAD)
                    load_timer(s_tdata);
                else
                    advance_tick();
            end
            if (m_tvalid && m_tready)
            begin
                if (status_queue.size() == 0)
                    report_mismatch($sformatf("status word %h with nothing expected", m_tdata));
                else
                begin
                    want = status_queue.pop_front();
                    check_field("index", int'(m_tdata[1:0]), int'(want.index));
                    check_field("minutes", int'(m_tdata[9:2]), int'(want.minutes));
                    check_field("seconds", int'(m_tdata[15:10]), int'(want.seconds));
                    check_field("running", int'(m_tdata[16]), int'(want.running));
                    check_field("expired", int'(m_tdata[17]), int'(want.expired));
                    check_field("timestamp", int'(m_tdata[25:18]), int'(want.stamp));
                    check_field("last", int'(m_tlast), int'(want.last));
                end
            end
            outstanding <= status_queue.size();
        end
    end

endmodule

// ===== test/testbench.sv =====
// Top of the countdown bank testbench: clock, reset, stimulus, output stalls and verdict.
module testbench
    import ftcb_pkg::*;
();

    localparam int IDLE_LIMIT    = 3000;
    localparam int SETTLE_CYCLES = 20;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tready = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [31:0] m_tdata;
    wire         m_tlast;
    int          mismatches;
    int          outstanding;
    int          idle_cycles = 0;
    int          burst_left = 0;
    int          ready_run = 0;

    fractional_tick_countdown_bank_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    timer_status_checker checker_inst (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    // The receiver alternates short runs of toggling ready with long stretches of steady ready.
    always @(posedge clk)
    begin
        if (ready_run == 0)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b1;
                ready_run <= $urandom_range(20, 60);
            end
            else
            begin
                m_tready <= ~m_tready;
                ready_run <= $urandom_range(1, 5);
            end
        end
        else
            ready_run <= ready_run - 1;
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_word(input logic act, input logic [23:0] word);
        int gap;
        s_tuser <= act;
        s_tdata <= word;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = $urandom_range(0, 6);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_tick();
        send_word(ACT_TICK, 24'($urandom_range(0, 24'hFFFFFF)));
    endtask

    task automatic send_load(input logic [1:0] idx, input logic [7:0] mins,
                             input logic [5:0] secs, input logic [6:0] sub,
                             input logic run);
        send_word(ACT_LOAD, {run, sub, secs, mins, idx});
    endtask

    task automatic random_load();
        logic [7:0] mins;
        logic [5:0] secs;
        mins = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 2));
        secs = $urandom_range(0, 1) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 5));
        send_load(2'($urandom_range(0, 3)), mins, secs, 7'($urandom_range(0, 127)),
                  $urandom_range(0, 7) != 0);
    endtask

    // Waits until every status word has arrived and the sequencer has settled.
    task automatic quiesce();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_timing(input logic [6:0] step, input logic [7:0] period,
                              input logic enable);
        logic [6:0] junk;
        quiesce();
        junk = 7'($urandom_range(0, 127));
        cfg_we <= 1'b1;
        cfg_index <= CFG_INCREMENT;
        cfg_data <= {junk[0], step};
        @(posedge clk);
        cfg_index <= CFG_MODULUS;
        cfg_data <= period;
        @(posedge clk);
        cfg_index <= CFG_ENABLE;
        cfg_data <= {junk, enable};
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [6:0] step;
        logic [7:0] period;
        logic       enable;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Countdowns disabled after reset: timers hold but still report.
        send_tick();
        send_load(2'd0, 8'd0, 6'd0, 7'd0, 1'b1);
        send_tick();

        // Expiry from zero, subsecond clamp, minute borrow, seconds above 59.
        set_timing(7'd16, 8'd125, 1'b1);
        send_tick();
        send_load(2'd1, 8'd255, 6'd59, 7'd127, 1'b1);
        send_load(2'd2, 8'd1, 6'd0, 7'd3, 1'b1);
        send_load(2'd3, 8'd0, 6'd63, 7'd5, 1'b0);
        send_load(2'd0, 8'd0, 6'd1, 7'd0, 1'b1);
        send_tick();
        send_tick();

        // Largest increment with a modulus of 128.
        set_timing(7'd127, 8'd128, 1'b1);
        send_tick();
        send_tick();

        // Modulus below the increment lets the accumulator overflow.
        set_timing(7'd127, 8'd1, 1'b1);
        send_load(2'd0, 8'd2, 6'd59, 7'd127, 1'b1);
        send_tick();
        send_tick();
        send_tick();

        // Zero modulus and zero increment.
        set_timing(7'd0, 8'd0, 1'b1);
        send_load(2'd2, 8'd0, 6'd3, 7'd100, 1'b1);
        send_tick();
        send_tick();

        set_timing(7'd5, 8'd128, 1'b0);
        send_load(2'd3, 8'd0, 6'd63, 7'd0, 1'b1);
        send_tick();

        for (int p = 0; p < 8; p++)
        begin
            case ($urandom_range(0, 5))
                0:       step = 7'd127;
                1:       step = 7'd1;
                default: step = 7'($urandom_range(1, 127));
            endcase
            case ($urandom_range(0, 5))
                0:       period = 8'd128;
                1:       period = {1'b0, step};
                2:       period = 8'($urandom_range(0, 128));
                default: period = 8'($urandom_range(step, 128));
            endcase
            enable = ($urandom_range(0, 7) != 0);
            set_timing(step, period, enable);
            for (int n = 0; n < 25; n++)
            begin
                if ($urandom_range(0, 99) < 35)
                    random_load();
                else
                    send_tick();
            end
        end

        quiesce();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ftcb_pkg.sv
rtl/ftcb_ram.sv
rtl/fractional_tick_countdown_bank_unit.sv
test/timer_status_checker.sv
test/testbench.sv
